// ----- hdl/lmfs_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lmfs_pkg: shared types and codes for the LED matrix frame buffer scanner
// Item kinds, colour bit positions, controller states and the structs that
// pass between the controller and the row shifter.
// ----------------------------------------------------------------------------
package lmfs_pkg;

    // Item kinds on the input channel.
    localparam logic [1:0] KIND_DRAW = 2'd0;
    localparam logic [1:0] KIND_FILL = 2'd1;
    localparam logic [1:0] KIND_TICK = 2'd2;

    // Bit positions of the colour field.
    localparam int COLOR_RED_BIT   = 0;
    localparam int COLOR_GREEN_BIT = 1;

    // One frame buffer byte holds eight pixels, leftmost in the MSB.
    localparam int BYTE_BITS = 8;
    // A memory word holds the red byte above the green byte.
    localparam int WORD_W    = 2 * BYTE_BITS;
    // Offset from an upper scan line to its partner in the lower half.
    localparam int SCAN_LINES = 16;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DRAW_RD,
        ST_DRAW_WR,
        ST_FETCH,
        ST_LOAD,
        ST_SHIFT
    } state_t;

    typedef struct packed {
        logic load;
        logic shift;
    } shift_ctrl_t;

    typedef struct packed {
        logic [BYTE_BITS-1:0] red_upper;
        logic [BYTE_BITS-1:0] red_lower;
        logic [BYTE_BITS-1:0] green_upper;
        logic [BYTE_BITS-1:0] green_lower;
    } pix_bytes_t;

    typedef struct packed {
        logic red_upper;
        logic red_lower;
        logic green_upper;
        logic green_lower;
    } pix_bits_t;

endpackage
`default_nettype wire

// ----- hdl/lmfs_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lmfs_ram: frame buffer memory
// One write port and two read ports, read data registered and held while
// the read enable is low.
// ----------------------------------------------------------------------------
module lmfs_ram #(
    parameter int ADDR_W = 8,
    parameter int DATA_W = 16
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re_a,
    input  wire logic [ADDR_W-1:0] raddr_a,
    output      logic [DATA_W-1:0] rdata_a,
    input  wire logic              re_b,
    input  wire logic [ADDR_W-1:0] raddr_b,
    output      logic [DATA_W-1:0] rdata_b
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re_a)
        begin
            rdata_a <= mem[raddr_a];
        end
        if (re_b)
        begin
            rdata_b <= mem[raddr_b];
        end
    end

endmodule
`default_nettype wire

// ----- hdl/lmfs_row_shift.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lmfs_row_shift: column serialiser
// Four byte-wide shift registers, one per colour line, that present one
// pixel column per shift, leftmost pixel first.
// ----------------------------------------------------------------------------
module lmfs_row_shift (
    input  wire logic                clk,
    input  wire lmfs_pkg::shift_ctrl_t ctrl,
    input  wire lmfs_pkg::pix_bytes_t  load_data,
    output      lmfs_pkg::pix_bits_t   bits
);

    lmfs_pkg::pix_bytes_t sr_reg;
    lmfs_pkg::pix_bytes_t sr_next;

    always_comb
    begin
        sr_next = sr_reg;
        if (ctrl.load)
        begin
            sr_next = load_data;
        end
        else if (ctrl.shift)
        begin
            sr_next.red_upper   = {sr_reg.red_upper[lmfs_pkg::BYTE_BITS-2:0], 1'b0};
            sr_next.red_lower   = {sr_reg.red_lower[lmfs_pkg::BYTE_BITS-2:0], 1'b0};
            sr_next.green_upper = {sr_reg.green_upper[lmfs_pkg::BYTE_BITS-2:0], 1'b0};
            sr_next.green_lower = {sr_reg.green_lower[lmfs_pkg::BYTE_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        sr_reg <= sr_next;
    end

    assign bits.red_upper   = sr_reg.red_upper[lmfs_pkg::BYTE_BITS-1];
    assign bits.red_lower   = sr_reg.red_lower[lmfs_pkg::BYTE_BITS-1];
    assign bits.green_upper = sr_reg.green_upper[lmfs_pkg::BYTE_BITS-1];
    assign bits.green_lower = sr_reg.green_lower[lmfs_pkg::BYTE_BITS-1];

endmodule
`default_nettype wire

// ----- hdl/led_matrix_framebuffer_scan.sv -----
// Tick item: FETCH and LOAD precede the first column result, then one column per cycle while
//   the output does not stall; the next item is taken once the last column is pushed.
// Draw item: read then write of one frame buffer byte, then back to idle; fill item:
//   one write per memory word, after which the next item is taken.
// Reset: asynchronous, active low; afterwards a clearing pass over every word darkens the
//   frame buffer, during which no item is accepted.
`default_nettype none
// ----------------------------------------------------------------------------
// led_matrix_framebuffer_scan: two-colour frame buffer and 1/16 scan driver
// Holds red and green bit planes for the panel and shifts one scan row out
// per tick, one column per cycle while the output does not stall, with active-low colour lines.
// ----------------------------------------------------------------------------
module led_matrix_framebuffer_scan #(
    parameter int PANEL_WIDTH  = 64,
    parameter int PANEL_HEIGHT = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input channel
    input  wire logic        in_valid,
    output      logic        in_ready,
    input  wire logic [1:0]  kind,
    input  wire logic [15:0] x,
    input  wire logic [15:0] y,
    input  wire logic [1:0]  color,
    // Output channel
    output      logic        out_valid,
    input  wire logic        out_ready,
    output      logic [5:0]  column,
    output      logic        red_upper_n,
    output      logic        red_lower_n,
    output      logic        green_upper_n,
    output      logic        green_lower_n,
    output      logic [3:0]  row_address,
    output      logic        latch
);

    // Each panel row takes a whole number of bytes; the byte index within a
    // row is padded to a power of two so that an address is simply the row
    // number above the byte number.
    localparam int ROW_BYTES  = (PANEL_WIDTH + 7) / 8;
    localparam int BYTE_W     = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
    // Only rows 0 to 31 are ever scanned (upper line plus sixteen), so rows
    // beyond that are never stored: drawing there has no visible effect.
    localparam int STORE_ROWS = (PANEL_HEIGHT < 32) ? PANEL_HEIGHT : 32;
    localparam int ROW_W      = (STORE_ROWS > 1) ? $clog2(STORE_ROWS) : 1;
    localparam int ADDR_W     = ROW_W + BYTE_W;
    localparam int COL_W      = $clog2(PANEL_WIDTH);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    lmfs_pkg::state_t state_reg, state_next;

    logic [3:0]                  scan_row_reg, scan_row_next;
    logic [ADDR_W-1:0]           clr_addr_reg, clr_addr_next;
    logic [lmfs_pkg::WORD_W-1:0] fill_word_reg, fill_word_next;
    logic [COL_W-1:0]            col_cnt_reg, col_cnt_next;
    logic [BYTE_W:0]             byte_idx_reg, byte_idx_next;
    logic [ADDR_W-1:0]           draw_addr_reg;
    logic [2:0]                  draw_bit_reg;
    logic [1:0]                  draw_color_reg;
    logic                        out_valid_reg, out_valid_next;

    logic [5:0]          column_reg;
    lmfs_pkg::pix_bits_t out_bits_reg;
    logic [3:0]          row_address_reg;
    logic                latch_reg;

    // ------------------------------------------------------------------
    // Control and datapath signals
    // ------------------------------------------------------------------
    logic in_accept;
    logic draw_ok;
    logic upper_ok;
    logic lower_ok;
    logic last_col;
    logic byte_end;
    logic more_bytes;
    logic push;
    logic fetch;

    logic                        ram_we;
    logic [ADDR_W-1:0]           ram_waddr;
    logic [lmfs_pkg::WORD_W-1:0] ram_wdata;
    logic                        ram_re_a;
    logic [ADDR_W-1:0]           ram_raddr_a;
    logic [lmfs_pkg::WORD_W-1:0] ram_rdata_a;
    logic [ADDR_W-1:0]           ram_raddr_b;
    logic [lmfs_pkg::WORD_W-1:0] ram_rdata_b;
    logic [ADDR_W-1:0]           fetch_addr_upper;
    logic [ADDR_W-1:0]           fetch_addr_lower;

    logic [lmfs_pkg::BYTE_BITS-1:0] draw_mask;
    logic [lmfs_pkg::BYTE_BITS-1:0] draw_red;
    logic [lmfs_pkg::BYTE_BITS-1:0] draw_green;

    lmfs_pkg::shift_ctrl_t sh_ctrl;
    lmfs_pkg::pix_bytes_t  sh_load;
    lmfs_pkg::pix_bits_t   sh_bits;

    assign in_ready  = (state_reg == lmfs_pkg::ST_IDLE);
    assign in_accept = in_valid && in_ready;

    // A draw lands only on a stored pixel; anything off the panel, or on a
    // row that is never scanned, leaves the frame buffer alone.
    assign draw_ok = !x[15] && (x[14:0] < 15'(PANEL_WIDTH))
                  && !y[15] && (y[14:0] < 15'(STORE_ROWS));

    // Scan lines beyond the panel height read as dark.
    assign upper_ok = (32'(scan_row_reg) < 32'(PANEL_HEIGHT));
    assign lower_ok = ((32'(scan_row_reg) + 32'(lmfs_pkg::SCAN_LINES)) < 32'(PANEL_HEIGHT));

    assign last_col   = (col_cnt_reg == COL_W'(PANEL_WIDTH - 1));
    assign byte_end   = (col_cnt_reg[2:0] == 3'd7);
    assign more_bytes = (byte_idx_reg < (BYTE_W + 1)'(ROW_BYTES));

    assign fetch_addr_upper = {ROW_W'({1'b0, scan_row_reg}), byte_idx_reg[BYTE_W-1:0]};
    assign fetch_addr_lower = {ROW_W'({1'b1, scan_row_reg}), byte_idx_reg[BYTE_W-1:0]};

    // Read-modify-write of the one byte that a draw touches.
    assign draw_mask  = 8'h80 >> draw_bit_reg;
    assign draw_red   = draw_color_reg[lmfs_pkg::COLOR_RED_BIT]
                      ? (ram_rdata_a[15:8] | draw_mask) : (ram_rdata_a[15:8] & ~draw_mask);
    assign draw_green = draw_color_reg[lmfs_pkg::COLOR_GREEN_BIT]
                      ? (ram_rdata_a[7:0] | draw_mask) : (ram_rdata_a[7:0] & ~draw_mask);

    // Freshly fetched bytes, blanked where the scan line lies off the panel.
    assign sh_load.red_upper   = ram_rdata_a[15:8] & {8{upper_ok}};
    assign sh_load.green_upper = ram_rdata_a[7:0]  & {8{upper_ok}};
    assign sh_load.red_lower   = ram_rdata_b[15:8] & {8{lower_ok}};
    assign sh_load.green_lower = ram_rdata_b[7:0]  & {8{lower_ok}};

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lmfs_pkg::ST_CLEAR:
            begin
                if (clr_addr_reg == {ADDR_W{1'b1}})
                begin
                    state_next = lmfs_pkg::ST_IDLE;
                end
            end
            lmfs_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    unique case (kind)
                        lmfs_pkg::KIND_DRAW:
                            state_next = draw_ok ? lmfs_pkg::ST_DRAW_RD : lmfs_pkg::ST_IDLE;
                        lmfs_pkg::KIND_FILL: state_next = lmfs_pkg::ST_CLEAR;
                        lmfs_pkg::KIND_TICK: state_next = lmfs_pkg::ST_FETCH;
                        default:             state_next = lmfs_pkg::ST_IDLE;
                    endcase
                end
            end
            lmfs_pkg::ST_DRAW_RD: state_next = lmfs_pkg::ST_DRAW_WR;
            lmfs_pkg::ST_DRAW_WR: state_next = lmfs_pkg::ST_IDLE;
            lmfs_pkg::ST_FETCH:   state_next = lmfs_pkg::ST_LOAD;
            lmfs_pkg::ST_LOAD:    state_next = lmfs_pkg::ST_SHIFT;
            lmfs_pkg::ST_SHIFT:
            begin
                if (push && last_col)
                begin
                    state_next = lmfs_pkg::ST_IDLE;
                end
            end
            default: state_next = lmfs_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Controller outputs
    // ------------------------------------------------------------------
    // During a tick the next byte pair is fetched as soon as the current
    // one is loaded into the shifter, so the read data waits in the RAM
    // output register and the shifter never runs dry.
    always_comb
    begin
        ram_we        = 1'b0;
        ram_waddr     = clr_addr_reg;
        ram_wdata     = fill_word_reg;
        ram_re_a      = 1'b0;
        ram_raddr_a   = fetch_addr_upper;
        ram_raddr_b   = fetch_addr_lower;
        sh_ctrl.load  = 1'b0;
        sh_ctrl.shift = 1'b0;
        push          = 1'b0;
        fetch         = 1'b0;
        unique case (state_reg)
            lmfs_pkg::ST_CLEAR:
            begin
                ram_we = 1'b1;
            end
            lmfs_pkg::ST_IDLE:
            begin
                fetch = 1'b0;
            end
            lmfs_pkg::ST_DRAW_RD:
            begin
                ram_re_a    = 1'b1;
                ram_raddr_a = draw_addr_reg;
            end
            lmfs_pkg::ST_DRAW_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = draw_addr_reg;
                ram_wdata = {draw_red, draw_green};
            end
            lmfs_pkg::ST_FETCH:
            begin
                fetch    = 1'b1;
                ram_re_a = 1'b1;
            end
            lmfs_pkg::ST_LOAD:
            begin
                sh_ctrl.load = 1'b1;
                fetch        = more_bytes;
                ram_re_a     = more_bytes;
            end
            lmfs_pkg::ST_SHIFT:
            begin
                push = !out_valid_reg || out_ready;
                if (push && !last_col)
                begin
                    if (byte_end)
                    begin
                        sh_ctrl.load = 1'b1;
                        fetch        = more_bytes;
                        ram_re_a     = more_bytes;
                    end
                    else
                    begin
                        sh_ctrl.shift = 1'b1;
                    end
                end
            end
            default:
            begin
                fetch = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Counters and control registers
    // ------------------------------------------------------------------
    always_comb
    begin
        scan_row_next  = scan_row_reg;
        clr_addr_next  = clr_addr_reg;
        fill_word_next = fill_word_reg;
        col_cnt_next   = col_cnt_reg;
        byte_idx_next  = byte_idx_reg;
        out_valid_next = out_valid_reg;

        if (state_reg == lmfs_pkg::ST_CLEAR)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
        end

        if (in_accept && (kind == lmfs_pkg::KIND_FILL))
        begin
            clr_addr_next  = '0;
            fill_word_next = {{8{color[lmfs_pkg::COLOR_RED_BIT]}},
                              {8{color[lmfs_pkg::COLOR_GREEN_BIT]}}};
        end

        if (in_accept && (kind == lmfs_pkg::KIND_TICK))
        begin
            col_cnt_next  = '0;
            byte_idx_next = '0;
        end
        else if (fetch)
        begin
            byte_idx_next = byte_idx_reg + 1'b1;
        end

        if (push)
        begin
            out_valid_next = 1'b1;
            if (last_col)
            begin
                scan_row_next = scan_row_reg + 1'b1;
            end
            else
            begin
                col_cnt_next = col_cnt_reg + 1'b1;
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lmfs_pkg::ST_CLEAR;
            scan_row_reg  <= '0;
            clr_addr_reg  <= '0;
            fill_word_reg <= '0;
            col_cnt_reg   <= '0;
            byte_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_row_reg  <= scan_row_next;
            clr_addr_reg  <= clr_addr_next;
            fill_word_reg <= fill_word_next;
            col_cnt_reg   <= col_cnt_next;
            byte_idx_reg  <= byte_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            draw_addr_reg  <= {y[ROW_W-1:0], x[3 +: BYTE_W]};
            draw_bit_reg   <= x[2:0];
            draw_color_reg <= color;
        end
        if (push)
        begin
            column_reg      <= 6'(col_cnt_reg);
            out_bits_reg    <= sh_bits;
            row_address_reg <= last_col ? scan_row_reg : 4'd0;
            latch_reg       <= last_col;
        end
    end

    // ------------------------------------------------------------------
    // Frame buffer and column serialiser
    // ------------------------------------------------------------------
    lmfs_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (lmfs_pkg::WORD_W)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .re_a    (ram_re_a),
        .raddr_a (ram_raddr_a),
        .rdata_a (ram_rdata_a),
        .re_b    (fetch),
        .raddr_b (ram_raddr_b),
        .rdata_b (ram_rdata_b)
    );

    lmfs_row_shift u_row_shift (
        .clk       (clk),
        .ctrl      (sh_ctrl),
        .load_data (sh_load),
        .bits      (sh_bits)
    );

    // ------------------------------------------------------------------
    // Outputs: the colour lines are active low
    // ------------------------------------------------------------------
    assign out_valid     = out_valid_reg;
    assign column        = column_reg;
    assign red_upper_n   = ~out_bits_reg.red_upper;
    assign red_lower_n   = ~out_bits_reg.red_lower;
    assign green_upper_n = ~out_bits_reg.green_upper;
    assign green_lower_n = ~out_bits_reg.green_lower;
    assign row_address   = row_address_reg;
    assign latch         = latch_reg;

`ifndef ASSERT_OFF
    // The latch only ever marks the rightmost column of a row.
    a_latch_last_column: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && latch) |-> (column == 6'(PANEL_WIDTH - 1)))
        else $error("latch raised on a column other than the last");

    // The row address is zero on every column but the latching one.
    a_row_address_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !latch) |-> (row_address == 4'd0))
        else $error("row address driven before latch");

    // Finishing a row moves the scan on by exactly one line.
    a_scan_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lmfs_pkg::ST_SHIFT && state_next == lmfs_pkg::ST_IDLE)
        |=> (scan_row_reg == 4'($past(scan_row_reg) + 4'd1)))
        else $error("scan row did not advance by one after a row");

    // Prefetching never runs past the end of a row.
    a_fetch_bound: assert property (@(posedge clk) disable iff (!rst_n)
        byte_idx_reg <= (BYTE_W + 1)'(ROW_BYTES))
        else $error("byte fetch ran beyond the row");
`endif

endmodule
`default_nettype wire

// ----- tb/tb_led_matrix_framebuffer_scan.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_led_matrix_framebuffer_scan: self-checking bench for the scan driver
// Draw, fill and tick items are sent over the input channel. A bit-level
// copy of the red and green planes and the scan row predicts every column
// result. Each column that comes out is checked against the oldest one
// predicted, through phases with and without idling on either side.
// ----------------------------------------------------------------------------
module tb_led_matrix_framebuffer_scan;

    // Panel geometry as the block is built by default.
    localparam int PANEL_W = 64;
    localparam int PANEL_H = 32;

    // The fourth kind code has no meaning and the block drops the item.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // Colour codes of the colour field.
    localparam logic [1:0] COLOR_OFF    = 2'd0;
    localparam logic [1:0] COLOR_RED    = 2'd1;
    localparam logic [1:0] COLOR_GREEN  = 2'd2;
    localparam logic [1:0] COLOR_ORANGE = 2'd3;

    // A fill or the clearing pass after reset holds the input off while it
    // writes every frame buffer word; the limit leaves a wide margin for that.
    localparam int WATCHDOG_LIMIT = 2000;
    // Cycles left to run once the last column has arrived, enough for a
    // fill still in flight to finish and for any stray column to show.
    localparam int SETTLE_CYCLES  = 300;
    // Random items in each of the four phases.
    localparam int ITEMS_PER_PHASE = 34;

    typedef struct {
        logic [1:0]  kind;
        logic [15:0] x;
        logic [15:0] y;
        logic [1:0]  color;
    } panel_item_t;

    typedef struct {
        logic [5:0] column;
        logic       red_upper_n;
        logic       red_lower_n;
        logic       green_upper_n;
        logic       green_lower_n;
        logic [3:0] row_address;
        logic       latch;
    } column_beat_t;

    // ------------------------------------------------------------------
    // Clock, reset and the ports of the block. Every input starts known.
    // ------------------------------------------------------------------
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [1:0]  kind      = lmfs_pkg::KIND_DRAW;
    logic [15:0] x         = '0;
    logic [15:0] y         = '0;
    logic [1:0]  color     = COLOR_OFF;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [5:0]  column;
    logic        red_upper_n;
    logic        red_lower_n;
    logic        green_upper_n;
    logic        green_lower_n;
    logic [3:0]  row_address;
    logic        latch;

    always #10 clk = ~clk;

    led_matrix_framebuffer_scan dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .x             (x),
        .y             (y),
        .color         (color),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .column        (column),
        .red_upper_n   (red_upper_n),
        .red_lower_n   (red_lower_n),
        .green_upper_n (green_upper_n),
        .green_lower_n (green_lower_n),
        .row_address   (row_address),
        .latch         (latch)
    );

    // ------------------------------------------------------------------
    // Bench state. The pixel arrays mirror the frame buffer one bit per
    // pixel, indexed by row and then column, and scan_row mirrors the
    // block's own row counter.
    // ------------------------------------------------------------------
    panel_item_t  pending_items[$];
    column_beat_t expected_columns[$];
    logic         red_px   [0:PANEL_H-1][0:PANEL_W-1];
    logic         green_px [0:PANEL_H-1][0:PANEL_W-1];
    logic [3:0]   scan_row;
    panel_item_t  driven_item;
    column_beat_t oldest_column;
    int           error_count  = 0;
    int           quiet_cycles = 0;
    int           sender_idle_pct    = 0;
    int           receiver_stall_pct = 0;

    // Idling plan of the random phases: none, sender only, receiver only,
    // then both sides together.
    int           sender_plan[4]   = '{0, 57, 0, 31};
    int           receiver_plan[4] = '{0, 0, 57, 31};

    // A draw lands only when both coordinates fall on the panel.
    function automatic bit off_panel(input logic [15:0] px, input logic [15:0] py);
        int sx;
        int sy;
        sx = int'($signed(px));
        sy = int'($signed(py));
        return (sx < 0 || sx >= PANEL_W || sy < 0 || sy >= PANEL_H);
    endfunction

    // Applies one accepted item to the mirrored frame buffer. A tick reads
    // out the current scan line and its partner sixteen rows below, one
    // column at a time, and queues the columns the block must shift out.
    task automatic update_framebuffer(input logic [1:0] k, input logic [15:0] px,
                                      input logic [15:0] py, input logic [1:0] c);
        int           upper;
        int           lower;
        column_beat_t beat;
        case (k)
            lmfs_pkg::KIND_DRAW:
                if (!off_panel(px, py))
                begin
                    red_px[$signed(py)][$signed(px)]   = c[lmfs_pkg::COLOR_RED_BIT];
                    green_px[$signed(py)][$signed(px)] = c[lmfs_pkg::COLOR_GREEN_BIT];
                end
            lmfs_pkg::KIND_FILL:
                for (int r = 0; r < PANEL_H; r++)
                begin
                    for (int col = 0; col < PANEL_W; col++)
                    begin
                        red_px[r][col]   = c[lmfs_pkg::COLOR_RED_BIT];
                        green_px[r][col] = c[lmfs_pkg::COLOR_GREEN_BIT];
                    end
                end
            lmfs_pkg::KIND_TICK:
            begin
                upper = int'(scan_row);
                lower = upper + lmfs_pkg::SCAN_LINES;
                for (int col = 0; col < PANEL_W; col++)
                begin
                    beat.column        = col[5:0];
                    beat.red_upper_n   = ~red_px[upper][col];
                    beat.green_upper_n = ~green_px[upper][col];
                    // A row below the panel would read as dark.
                    beat.red_lower_n   = (lower < PANEL_H) ? ~red_px[lower][col] : 1'b1;
                    beat.green_lower_n = (lower < PANEL_H) ? ~green_px[lower][col] : 1'b1;
                    beat.latch         = (col == PANEL_W - 1);
                    beat.row_address   = beat.latch ? scan_row : 4'd0;
                    expected_columns.push_back(beat);
                end
                scan_row = scan_row + 4'd1;
            end
            default: ;
        endcase
    endtask

    task automatic push_item(input logic [1:0] k, input int px, input int py,
                             input logic [1:0] c);
        panel_item_t it;
        it.kind  = k;
        it.x     = px[15:0];
        it.y     = py[15:0];
        it.color = c;
        pending_items.push_back(it);
    endtask

    // Random traffic is mostly draws on the panel with ticks in between, so
    // that the scanned rows carry a varied picture. The rest is draws with
    // arbitrary 16-bit coordinates, fills and items of the unused kind.
    function automatic panel_item_t random_item();
        panel_item_t it;
        int          pick;
        pick     = $urandom_range(99);
        it.x     = 16'($urandom);
        it.y     = 16'($urandom);
        it.color = 2'($urandom_range(3));
        if (pick < 48)
        begin
            it.kind = lmfs_pkg::KIND_DRAW;
            it.x    = 16'($urandom_range(PANEL_W - 1));
            it.y    = 16'($urandom_range(PANEL_H - 1));
        end
        else if (pick < 58)
            it.kind = lmfs_pkg::KIND_DRAW;
        else if (pick < 63)
            it.kind = lmfs_pkg::KIND_FILL;
        else if (pick < 67)
            it.kind = KIND_UNUSED;
        else
            it.kind = lmfs_pkg::KIND_TICK;
        return it;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    // Waits until every queued item has gone in and every column has come
    // out. Sampling on the falling edge keeps clear of the driver's updates.
    task automatic wait_for_drain();
        while (pending_items.size() != 0 || in_valid || expected_columns.size() != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Driver: presents the next pending item once the previous one has
    // been taken, unless this cycle is chosen as an idle one.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_ready)
        begin
            if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                driven_item = pending_items.pop_front();
                in_valid    <= 1'b1;
                kind        <= driven_item.kind;
                x           <= driven_item.x;
                y           <= driven_item.y;
                color       <= driven_item.color;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // The receiver stalls at random, independently of what is on offer.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // ------------------------------------------------------------------
    // Monitor: checks each column taken against the oldest prediction,
    // feeds each accepted item to the predictor and runs the watchdog.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_columns.size() == 0)
                begin
                    $display("%0t: column result mismatch, expected none, actual column %0d",
                             $time, column);
                    error_count++;
                end
                else
                begin
                    oldest_column = expected_columns.pop_front();
                    check_field("column", int'(oldest_column.column), int'(column));
                    check_field("red_upper_n", int'(oldest_column.red_upper_n),
                                int'(red_upper_n));
                    check_field("red_lower_n", int'(oldest_column.red_lower_n),
                                int'(red_lower_n));
                    check_field("green_upper_n", int'(oldest_column.green_upper_n),
                                int'(green_upper_n));
                    check_field("green_lower_n", int'(oldest_column.green_lower_n),
                                int'(green_lower_n));
                    check_field("row_address", int'(oldest_column.row_address),
                                int'(row_address));
                    check_field("latch", int'(oldest_column.latch), int'(latch));
                end
            end
            if (in_valid && in_ready)
                update_framebuffer(kind, x, y, color);
            // The watchdog only counts cycles in which neither side moves.
            if ((out_valid && out_ready) || (in_valid && in_ready))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("FAILURE");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus: a directed opening, then four random phases with their
    // own idling. Between phases the sender holds off until every column
    // owed has been received.
    // ------------------------------------------------------------------
    initial
    begin
        // The frame buffer comes out of reset dark, scanning row zero.
        for (int r = 0; r < PANEL_H; r++)
        begin
            for (int col = 0; col < PANEL_W; col++)
            begin
                red_px[r][col]   = 1'b0;
                green_px[r][col] = 1'b0;
            end
        end
        scan_row = 4'd0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Corners and edges of the first two scan lines and their partners
        // in the lower half, with one pixel set and then switched off.
        push_item(lmfs_pkg::KIND_DRAW, 0, 0, COLOR_RED);
        push_item(lmfs_pkg::KIND_DRAW, PANEL_W - 1, 0, COLOR_GREEN);
        push_item(lmfs_pkg::KIND_DRAW, 0, lmfs_pkg::SCAN_LINES, COLOR_ORANGE);
        push_item(lmfs_pkg::KIND_DRAW, PANEL_W - 1, lmfs_pkg::SCAN_LINES + 1, COLOR_ORANGE);
        push_item(lmfs_pkg::KIND_DRAW, PANEL_W - 2, 1, COLOR_RED);
        push_item(lmfs_pkg::KIND_DRAW, PANEL_W - 2, 1, COLOR_OFF);
        push_item(lmfs_pkg::KIND_DRAW, 1, 1, COLOR_GREEN);
        // Draws just off each edge and at the extremes of the coordinates
        // must leave the picture alone.
        push_item(lmfs_pkg::KIND_DRAW, -1, 0, COLOR_ORANGE);
        push_item(lmfs_pkg::KIND_DRAW, PANEL_W, 0, COLOR_ORANGE);
        push_item(lmfs_pkg::KIND_DRAW, 0, -1, COLOR_ORANGE);
        push_item(lmfs_pkg::KIND_DRAW, 0, PANEL_H, COLOR_ORANGE);
        push_item(lmfs_pkg::KIND_DRAW, -32768, 32767, COLOR_ORANGE);
        push_item(lmfs_pkg::KIND_DRAW, 32767, -32768, COLOR_ORANGE);
        push_item(KIND_UNUSED, 5, 5, COLOR_ORANGE);
        push_item(lmfs_pkg::KIND_TICK, 0, 0, COLOR_OFF);
        push_item(lmfs_pkg::KIND_TICK, 0, 0, COLOR_OFF);
        // Every fill colour, each followed by a scan of the result.
        push_item(lmfs_pkg::KIND_FILL, 0, 0, COLOR_ORANGE);
        push_item(lmfs_pkg::KIND_TICK, 0, 0, COLOR_OFF);
        push_item(lmfs_pkg::KIND_FILL, 0, 0, COLOR_RED);
        push_item(lmfs_pkg::KIND_TICK, 0, 0, COLOR_OFF);
        push_item(lmfs_pkg::KIND_FILL, 0, 0, COLOR_GREEN);
        push_item(lmfs_pkg::KIND_TICK, 0, 0, COLOR_OFF);
        push_item(lmfs_pkg::KIND_FILL, 0, 0, COLOR_OFF);
        push_item(lmfs_pkg::KIND_TICK, -1, -1, COLOR_ORANGE);
        wait_for_drain();

        // A fixed number of random items per phase, dropped ones included.
        for (int phase = 0; phase < 4; phase++)
        begin
            sender_idle_pct    = sender_plan[phase];
            receiver_stall_pct = receiver_plan[phase];
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                pending_items.push_back(random_item());
            wait_for_drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_columns.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/lmfs_pkg.sv
hdl/lmfs_ram.sv
hdl/lmfs_row_shift.sv
hdl/led_matrix_framebuffer_scan.sv
tb/tb_led_matrix_framebuffer_scan.sv
